/* design/calo_adc_bank_unpacker_macros.svh */
// ----------------------------------------------------------------------------
// calo adc bank unpacker assertion macros
// shared concurrent check forms, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef CALO_ADC_BANK_UNPACKER_MACROS_SVH
`define CALO_ADC_BANK_UNPACKER_MACROS_SVH

// same-cycle implication
`define CABU_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("cabu: same-cycle check failed");

// next-cycle implication
`define CABU_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("cabu: next-cycle check failed");

`endif

/* design/cabu_pkg.sv */
// ----------------------------------------------------------------------------
// cabu_pkg
// types, codes and constants shared by the adc bank unpacker modules
// ----------------------------------------------------------------------------
package cabu_pkg;

  localparam int unsigned CABU_CHANNELS_PER_CARD = 32;

  // configuration register indexes
  localparam logic REG_BANK_FORMAT = 1'b0;
  localparam logic REG_SKIP_HDR    = 1'b1;

  // bank encodings
  localparam logic [1:0] FMT_NONE   = 2'd0;
  localparam logic [1:0] FMT_PLAIN  = 2'd1;
  localparam logic [1:0] FMT_PACKED = 2'd2;
  localparam logic [1:0] FMT_LIST   = 2'd3;

  localparam logic [1:0] FMT_RESET = FMT_PACKED;

  // word operations handed from parser to serial unit
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_HDR    = 3'd1;
  localparam logic [2:0] OP_PAT    = 3'd2;
  localparam logic [2:0] OP_STREAM = 3'd3;
  localparam logic [2:0] OP_ENTRY  = 3'd4;
  localparam logic [2:0] OP_ONE    = 3'd5;

  typedef struct packed {
    logic [31:0] data_word;
    logic        bank_start;
  } cabu_in_t;

  typedef struct packed {
    logic        [15:0] cell_or_channel;
    logic signed [15:0] adc_value;
    logic        [8:0]  card_code;
    logic        [8:0]  card_ctrl;
    logic               last_of_word;
  } cabu_res_t;

  typedef struct packed {
    logic       load;
    logic       clr;
    logic [2:0] op;
    logic [6:0] ent;
  } cabu_cmd_t;

  typedef struct packed {
    logic chan_full;
    logic part_zero;
    logic ent_zero;
    logic card_done;
  } cabu_stat_t;

  typedef struct packed {
    logic cand;
    logic word_end;
  } cabu_ev_t;

endpackage

/* design/cabu_parser.sv */
// ----------------------------------------------------------------------------
// cabu_parser
// word-level bank parsing: phase, skipped words and card header fields
// ----------------------------------------------------------------------------
module cabu_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  cabu_pkg::cabu_in_t  in_i,
  input  logic [1:0]          fmt_i,
  input  logic                skip_hdr_i,
  input  cabu_pkg::cabu_stat_t stat_i,
  output cabu_pkg::cabu_cmd_t cmd_o,
  output logic [8:0]          code_o,
  output logic [8:0]          ctrl_o
);

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_SKIP    = 3'd2;
  localparam logic [2:0] PH_PATTERN = 3'd3;
  localparam logic [2:0] PH_DATA    = 3'd4;

  logic [2:0] phase_q, phase_d;
  logic [5:0] skip_q, skip_d;
  logic [8:0] code_q, code_d;
  logic [8:0] ctrl_q, ctrl_d;

  logic [2:0]  ph;
  logic [5:0]  skip_e;
  logic [5:0]  skip_dec;
  logic        ent_z;
  logic        chan_full;
  logic        part_zero;
  logic        drop;
  logic        take_hdr;
  logic [7:0]  lt_sum;
  logic [5:0]  hdr_skip;
  logic [6:0]  hdr_ent;
  logic [31:0] w;

  assign w        = in_i.data_word;
  assign lt_sum   = {1'b0, w[6:0]} + 8'd3;
  assign hdr_skip = lt_sum[7:2];
  assign hdr_ent  = (fmt_i == cabu_pkg::FMT_LIST) ? w[13:7] : 7'd0;

  always_comb begin
    phase_d   = phase_q;
    skip_d    = skip_q;
    code_d    = code_q;
    ctrl_d    = ctrl_q;
    cmd_o     = '0;
    ph        = phase_q;
    skip_e    = skip_q;
    skip_dec  = skip_q;
    ent_z     = stat_i.ent_zero;
    chan_full = stat_i.chan_full;
    part_zero = stat_i.part_zero;
    drop      = 1'b0;
    take_hdr  = 1'b0;

    if (stat_i.card_done) begin
      phase_d = PH_HEADER;
    end

    if (accept_i) begin
      cmd_o.load = 1'b1;
      cmd_o.clr  = in_i.bank_start;
      if (in_i.bank_start) begin
        ph        = PH_START;
        skip_e    = 6'd0;
        code_d    = 9'd0;
        ctrl_d    = 9'd0;
        ent_z     = 1'b1;
        chan_full = 1'b0;
        part_zero = 1'b1;
      end
      if (ph == PH_START) begin
        ph   = PH_HEADER;
        drop = skip_hdr_i;
      end
      skip_d  = skip_e;
      phase_d = ph;

      if (!drop) begin
        case (fmt_i)
          cabu_pkg::FMT_PLAIN: begin
            cmd_o.op = cabu_pkg::OP_ONE;
            phase_d  = PH_HEADER;
          end
          cabu_pkg::FMT_PACKED, cabu_pkg::FMT_LIST: begin
            case (ph)
              PH_SKIP: begin
                skip_dec = (skip_e != 6'd0) ? skip_e - 6'd1 : skip_e;
                skip_d   = skip_dec;
                if (skip_dec == 6'd0) begin
                  if (fmt_i == cabu_pkg::FMT_PACKED) begin
                    phase_d = PH_PATTERN;
                  end else begin
                    phase_d = ent_z ? PH_HEADER : PH_DATA;
                  end
                end
              end
              PH_PATTERN: begin
                if (fmt_i == cabu_pkg::FMT_PACKED) begin
                  cmd_o.op = cabu_pkg::OP_PAT;
                  phase_d  = PH_DATA;
                end else if (!ent_z) begin
                  cmd_o.op = cabu_pkg::OP_ENTRY;
                end else begin
                  take_hdr = 1'b1;
                end
              end
              PH_DATA: begin
                if (fmt_i == cabu_pkg::FMT_PACKED) begin
                  if (chan_full && part_zero) begin
                    take_hdr = 1'b1;
                  end else begin
                    cmd_o.op = cabu_pkg::OP_STREAM;
                  end
                end else if (!ent_z) begin
                  cmd_o.op = cabu_pkg::OP_ENTRY;
                end else begin
                  take_hdr = 1'b1;
                end
              end
              default: begin
                take_hdr = 1'b1;
              end
            endcase
          end
          default: begin
          end
        endcase

        if (take_hdr) begin
          cmd_o.op  = cabu_pkg::OP_HDR;
          cmd_o.ent = hdr_ent;
          code_d    = w[22:14];
          ctrl_d    = w[31:23];
          skip_d    = hdr_skip;
          if (hdr_skip != 6'd0) begin
            phase_d = PH_SKIP;
          end else if (fmt_i == cabu_pkg::FMT_PACKED) begin
            phase_d = PH_PATTERN;
          end else begin
            phase_d = (hdr_ent != 7'd0) ? PH_DATA : PH_HEADER;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      skip_q  <= 6'd0;
      code_q  <= 9'd0;
      ctrl_q  <= 9'd0;
    end else begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      code_q  <= code_d;
      ctrl_q  <= ctrl_d;
    end
  end

  assign code_o = code_q;
  assign ctrl_o = ctrl_q;

endmodule

/* design/cabu_serial.sv */
// ----------------------------------------------------------------------------
// cabu_serial
// digit-serial decoder: shifts a word out one nibble or entry per rdy_i cycle
// ----------------------------------------------------------------------------
module cabu_serial #(
  parameter int unsigned CHANNELS_PER_CARD = cabu_pkg::CABU_CHANNELS_PER_CARD
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cabu_pkg::cabu_cmd_t  cmd_i,
  input  logic [31:0]          word_i,
  input  logic [8:0]           code_i,
  input  logic [8:0]           ctrl_i,
  input  logic                 rdy_i,
  output cabu_pkg::cabu_ev_t   ev_o,
  output cabu_pkg::cabu_res_t  cand_o,
  output cabu_pkg::cabu_stat_t stat_o,
  output logic                 idle_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NIB  = 3'd1;
  localparam logic [2:0] S_ENT  = 3'd2;
  localparam logic [2:0] S_ONE  = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;

  localparam logic [1:0] KIND_ONE = 2'd0;
  localparam logic [1:0] KIND_NIB = 2'd1;
  localparam logic [1:0] KIND_ENT = 2'd2;

  localparam logic [5:0] ChanLimit = 6'(CHANNELS_PER_CARD);

  logic [2:0]  state_q, state_d;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] word_q, word_d;
  logic [2:0]  dig_q, dig_d;
  logic [31:0] pat_q, pat_d;
  logic [5:0]  chan_q, chan_d;
  logic [6:0]  ent_q, ent_d;
  logic [7:0]  acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;

  logic       chan_act;
  logic [3:0] nib;
  logic       long_bit;
  logic       done_chk;

  assign chan_act = chan_q < ChanLimit;
  assign nib      = word_q[3:0];
  assign long_bit = pat_q[chan_q[4:0]];

  always_comb begin
    case (kind_q)
      KIND_NIB: done_chk = !chan_act && (cnt_q == 2'd0);
      KIND_ENT: done_chk = (ent_q == 7'd0);
      default:  done_chk = 1'b0;
    endcase
  end

  assign stat_o.chan_full = !chan_act;
  assign stat_o.part_zero = (cnt_q == 2'd0);
  assign stat_o.ent_zero  = (ent_q == 7'd0);
  assign stat_o.card_done = (state_q == S_END) && rdy_i && done_chk;
  assign idle_o           = (state_q == S_IDLE);

  // result candidate for the current step
  always_comb begin
    cand_o                 = '0;
    cand_o.cell_or_channel = {10'd0, chan_q};
    cand_o.card_code       = code_i;
    cand_o.card_ctrl       = ctrl_i;
    case (state_q)
      S_NIB: begin
        if (long_bit) begin
          cand_o.adc_value = {4'd0, nib, acc_q} - 16'd256;
        end else begin
          cand_o.adc_value = {12'd0, nib} - 16'd8;
        end
      end
      S_ENT: begin
        cand_o.cell_or_channel = {10'd0, word_q[15:10]};
        cand_o.adc_value       = {6'd0, word_q[9:0]};
      end
      S_ONE: begin
        cand_o.cell_or_channel = word_q[31:16];
        cand_o.adc_value       = word_q[15:0];
        cand_o.card_code       = 9'd0;
        cand_o.card_ctrl       = 9'd0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    word_d  = word_q;
    dig_d   = dig_q;
    pat_d   = pat_q;
    chan_d  = chan_q;
    ent_d   = ent_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    ev_o    = '0;

    case (state_q)
      S_IDLE: begin
        if (cmd_i.load) begin
          if (cmd_i.clr) begin
            pat_d  = 32'd0;
            chan_d = 6'd0;
            ent_d  = 7'd0;
            acc_d  = 8'd0;
            cnt_d  = 2'd0;
          end
          case (cmd_i.op)
            cabu_pkg::OP_HDR: begin
              ent_d  = cmd_i.ent;
              chan_d = 6'd0;
              acc_d  = 8'd0;
              cnt_d  = 2'd0;
            end
            cabu_pkg::OP_PAT: begin
              pat_d  = word_i;
              chan_d = 6'd0;
              acc_d  = 8'd0;
              cnt_d  = 2'd0;
            end
            cabu_pkg::OP_STREAM: begin
              word_d  = word_i;
              dig_d   = 3'd0;
              kind_d  = KIND_NIB;
              state_d = S_NIB;
            end
            cabu_pkg::OP_ENTRY: begin
              word_d  = word_i;
              dig_d   = 3'd0;
              kind_d  = KIND_ENT;
              state_d = S_ENT;
            end
            cabu_pkg::OP_ONE: begin
              word_d  = word_i;
              kind_d  = KIND_ONE;
              state_d = S_ONE;
            end
            default: begin
            end
          endcase
        end
      end
      S_NIB: begin
        if (rdy_i) begin
          if (chan_act) begin
            if (long_bit) begin
              if (cnt_q == 2'd2) begin
                ev_o.cand = 1'b1;
                chan_d    = chan_q + 6'd1;
                cnt_d     = 2'd0;
                acc_d     = 8'd0;
              end else begin
                if (cnt_q == 2'd0) begin
                  acc_d[3:0] = nib;
                end else begin
                  acc_d[7:4] = nib;
                end
                cnt_d = cnt_q + 2'd1;
              end
            end else begin
              ev_o.cand = 1'b1;
              chan_d    = chan_q + 6'd1;
            end
          end
          word_d = word_q >> 4;
          dig_d  = dig_q + 3'd1;
          if (!chan_act || dig_q == 3'd7) begin
            state_d = S_END;
          end
        end
      end
      S_ENT: begin
        if (rdy_i) begin
          ev_o.cand = 1'b1;
          ent_d     = ent_q - 7'd1;
          word_d    = word_q >> 16;
          dig_d     = dig_q + 3'd1;
          if (dig_q[0] || ent_q == 7'd1) begin
            state_d = S_END;
          end
        end
      end
      S_ONE: begin
        if (rdy_i) begin
          ev_o.cand = 1'b1;
          state_d   = S_END;
        end
      end
      S_END: begin
        if (rdy_i) begin
          ev_o.word_end = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= KIND_ONE;
      dig_q   <= 3'd0;
      pat_q   <= 32'd0;
      chan_q  <= 6'd0;
      ent_q   <= 7'd0;
      acc_q   <= 8'd0;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      dig_q   <= dig_d;
      pat_q   <= pat_d;
      chan_q  <= chan_d;
      ent_q   <= ent_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

/* design/cabu_tagger.sv */
// ----------------------------------------------------------------------------
// cabu_tagger
// holds one result back to mark the last of each word, then output register
// ----------------------------------------------------------------------------
module cabu_tagger (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cabu_pkg::cabu_ev_t  ev_i,
  input  cabu_pkg::cabu_res_t cand_i,
  output logic                rdy_o,
  output logic                pend_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cabu_pkg::cabu_res_t out_data_o
);

  cabu_pkg::cabu_res_t pend_q, pend_d;
  logic                pend_v_q, pend_v_d;
  cabu_pkg::cabu_res_t out_q, out_d;
  logic                out_v_q, out_v_d;

  logic out_free;
  logic push;

  assign out_free = !out_v_q || out_ready_i;
  assign rdy_o    = !pend_v_q || out_free;
  assign push     = rdy_o && pend_v_q && (ev_i.cand || ev_i.word_end);

  always_comb begin
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q;

    if (rdy_o && ev_i.cand) begin
      pend_d   = cand_i;
      pend_v_d = 1'b1;
    end else if (rdy_o && ev_i.word_end) begin
      pend_v_d = 1'b0;
    end

    if (push) begin
      out_d              = pend_q;
      out_d.last_of_word = ev_i.word_end;
      out_v_d            = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign pend_o      = pend_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

/* design/calo_adc_bank_unpacker.sv */
// ----------------------------------------------------------------------------
// calo_adc_bank_unpacker
// unpacks calorimeter readout bank words into one beat per adc value
// ----------------------------------------------------------------------------
// A word is taken only while the nibble shifter is idle. Header, skipped
// trigger and pattern words leave it idle. A plain-format word passes load,
// one result and word close, a list-format word gives up to two entries
// (one entry per cycle) and a compressed data word leaves the shift register
// one nibble per cycle, at most eight nibbles, a long value being built over
// three of them; both rates hold only while the output takes results. Each
// result beat is held back one step so that the last beat of a word carries
// last_of_word; a stalled output holds the shifter, but the next word is
// still taken while a finished beat waits in the output register.
`include "calo_adc_bank_unpacker_macros.svh"

module calo_adc_bank_unpacker #(
  parameter int unsigned CHANNELS_PER_CARD = cabu_pkg::CABU_CHANNELS_PER_CARD
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [1:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cabu_pkg::cabu_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cabu_pkg::cabu_res_t out_data_o
);

  logic [1:0] fmt_q;
  logic       skip_hdr_q;

  logic                 in_acc;
  logic                 ser_idle;
  logic                 tag_rdy;
  logic                 tag_pend;
  cabu_pkg::cabu_cmd_t  cmd;
  cabu_pkg::cabu_stat_t stat;
  cabu_pkg::cabu_ev_t   ev;
  cabu_pkg::cabu_res_t  cand;
  logic [8:0]           code;
  logic [8:0]           ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q      <= cabu_pkg::FMT_RESET;
      skip_hdr_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cabu_pkg::REG_BANK_FORMAT: fmt_q      <= cfg_wdata_i;
        cabu_pkg::REG_SKIP_HDR:    skip_hdr_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = ser_idle;
  assign in_acc     = in_valid_i && in_ready_o;

  cabu_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_acc),
    .in_i       (in_data_i),
    .fmt_i      (fmt_q),
    .skip_hdr_i (skip_hdr_q),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .code_o     (code),
    .ctrl_o     (ctrl)
  );

  cabu_serial #(
    .CHANNELS_PER_CARD (CHANNELS_PER_CARD)
  ) u_serial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .word_i (in_data_i.data_word),
    .code_i (code),
    .ctrl_i (ctrl),
    .rdy_i  (tag_rdy),
    .ev_o   (ev),
    .cand_o (cand),
    .stat_o (stat),
    .idle_o (ser_idle)
  );

  cabu_tagger u_tagger (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_i        (ev),
    .cand_i      (cand),
    .rdy_o       (tag_rdy),
    .pend_o      (tag_pend),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // every beat of a word has left the hold stage once the shifter is idle
  `CABU_ASSERT_IMP(a_idle_no_pend, ser_idle, !tag_pend)
  // a step either carries a result or closes the word, never both
  `CABU_ASSERT_IMP(a_ev_excl, ev.cand || ev.word_end, !(ev.cand && ev.word_end))
  // a word under an unsupported format starts no serial work
  `CABU_ASSERT_NXT(a_nofmt_idle, in_acc && fmt_q == cabu_pkg::FMT_NONE, in_ready_o)

endmodule
